@@ rtl/mandelbrot_membership_top_defines.svh @@
// ----------------------------------------------------------------------------
// mandelbrot_membership_top_defines
// assertion macros for the mandelbrot membership top
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_MEMBERSHIP_TOP_DEFINES_SVH
`define MANDELBROT_MEMBERSHIP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbm assertion failed");
// next-cycle implication
`define MBM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbm assertion failed");
`else
`define MBM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MBM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/mbm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbm_pkg
// shared types and constants of the mandelbrot membership block
// ----------------------------------------------------------------------------
package mbm_pkg;

    localparam int PIX_W      = 12;
    localparam int DIM_CFG_W  = 13;
    localparam int ITER_W     = 16;
    localparam int IDX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [ITER_W-1:0]    RST_MAX_ITERATIONS = 16'd1000;

    typedef enum logic [1:0] {
        MSEL_XX,
        MSEL_YY,
        MSEL_XY
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL_GO,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_CHECK,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     set_cx;
        logic     set_cy;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     store;
        t_mul_sel store_sel;
        logic     prep;
        logic     update;
        logic     finish;
        logic     in_set;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic escape;
    } t_status;

endpackage

@@ rtl/mandelbrot_membership_top.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_membership_top
// escape-time mandelbrot membership test of one pixel per command
// ----------------------------------------------------------------------------
// a pixel is taken when start is high and busy is low; one beat comes back
// on o_valid for a single cycle and cannot be held off by the receiver.
// each pixel runs two coordinate divisions (one quotient bit a cycle)
// and then its orbit steps, at most max_iterations-1 of them. the step
// time is set by the single shared multiplier, which forms each of the
// three full-width products of a step from four half-width partial
// products.
`include "mandelbrot_membership_top_defines.svh"

module mandelbrot_membership_top #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mbm_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [mbm_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                            o_valid,
    output logic [mbm_pkg::IDX_W-1:0]       o_pixel_index,
    output logic                            o_in_set,
    input  logic                            i_cfg_we,
    input  logic [mbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mbm_pkg::*;

    logic [DIM_CFG_W-1:0] r_image_width;
    logic [DIM_CFG_W-1:0] r_image_height;
    logic [ITER_W-1:0]    r_max_iterations;

    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
            r_max_iterations <= RST_MAX_ITERATIONS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_MAX_ITERATIONS: r_max_iterations <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_max_iterations (r_max_iterations),
        .o_cmd            (cmd),
        .i_status         (status)
    );

    mbm_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_valid        (o_valid),
        .o_pixel_index  (o_pixel_index),
        .o_in_set       (o_in_set)
    );

    // result beat only appears once the sequencer is back in idle
    `MBM_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // an accepted pixel makes the block busy
    `MBM_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // one beat per pixel
    `MBM_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

@@ rtl/mbm_div.sv @@
// ----------------------------------------------------------------------------
// mbm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mbm_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/mbm_mul.sv @@
// ----------------------------------------------------------------------------
// mbm_mul
// unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
module mbm_mul #(
    parameter int OP_W = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_a,
    input  logic [OP_W-1:0]   i_b,
    output logic              o_done,
    output logic [2*OP_W-1:0] o_prod
);
    localparam int HALF  = (OP_W + 1) / 2;
    localparam int OPP_W = 2 * HALF;
    localparam int ACC_W = 4 * HALF;

    logic             r_busy;
    logic [1:0]       r_step;
    logic             r_pp_vld;
    logic             r_pp_last;
    logic             r_done;
    logic [OPP_W-1:0] r_a;
    logic [OPP_W-1:0] r_b;
    logic [OPP_W-1:0] r_pp;
    logic [1:0]       r_pp_sh;
    logic [ACC_W-1:0] r_acc;

    logic [HALF-1:0]  a_part;
    logic [HALF-1:0]  b_part;
    logic [1:0]       sh_code;
    logic [ACC_W-1:0] pp_ext;
    logic [ACC_W-1:0] pp_shift;

    assign a_part  = r_step[1] ? r_a[OPP_W-1:HALF] : r_a[HALF-1:0];
    assign b_part  = r_step[0] ? r_b[OPP_W-1:HALF] : r_b[HALF-1:0];
    assign sh_code = {1'b0, r_step[1]} + {1'b0, r_step[0]};
    assign pp_ext  = ACC_W'(r_pp);

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = pp_ext << HALF;
            default: pp_shift = pp_ext << OPP_W;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_busy;
            r_pp_last <= r_busy && (r_step == 2'd3);
            r_done    <= r_pp_vld && r_pp_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= OPP_W'(i_a);
            r_b   <= OPP_W'(i_b);
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + pp_shift;
        end
        r_pp    <= OPP_W'(a_part) * OPP_W'(b_part);
        r_pp_sh <= sh_code;
    end

    assign o_done = r_done;
    assign o_prod = r_acc[2*OP_W-1:0];

endmodule

@@ rtl/mbm_dp.sv @@
// ----------------------------------------------------------------------------
// mbm_dp
// datapath: coordinate mapping, orbit registers, step arithmetic, result
// ----------------------------------------------------------------------------
module mbm_dp #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbm_pkg::t_cmd                  i_cmd,
    output mbm_pkg::t_status               o_status,
    input  logic [mbm_pkg::PIX_W-1:0]      i_pixel_x,
    input  logic [mbm_pkg::PIX_W-1:0]      i_pixel_y,
    input  logic [mbm_pkg::DIM_CFG_W-1:0]  i_image_width,
    input  logic [mbm_pkg::DIM_CFG_W-1:0]  i_image_height,
    output logic                           o_valid,
    output logic [mbm_pkg::IDX_W-1:0]      o_pixel_index,
    output logic                           o_in_set
);
    import mbm_pkg::*;

    localparam int CW    = 12 + FRAC_BITS;
    localparam int MW    = CW + 1;
    localparam int SW    = CW + 3;
    localparam int SQW   = 2 * CW;
    localparam int DSH_W = SQW - FRAC_BITS;
    localparam int DVD_W = PIX_W + 2 + FRAC_BITS;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    localparam logic [MW-1:0]        CAP    = {1'b1, {CW{1'b0}}};
    localparam logic [SQW-1:0]       THR    = SQW'(100) << (2 * FRAC_BITS);
    localparam logic [63:0]          OFF_X64 = ((64'd22 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [SW-1:0]        OFF_X  = SW'(OFF_X64);
    localparam logic [SW-1:0]        OFF_Y  = SW'(64'd3 << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] S_HI   = SW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] S_LO   = ~S_HI;

    function automatic logic [CW-1:0] sat_c(input logic signed [SW-1:0] v);
        logic [CW-1:0] res;
        if (v > S_HI) begin
            res = S_HI[CW-1:0];
        end else if (v < S_LO) begin
            res = S_LO[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic [PIX_W-1:0]      r_py;
    logic [IDX_W-1:0]      r_idx;
    logic signed [CW-1:0]  r_cx;
    logic signed [CW-1:0]  r_cy;
    logic signed [CW-1:0]  r_x;
    logic signed [CW-1:0]  r_y;
    logic [SQW-1:0]        r_sx;
    logic [SQW-1:0]        r_sy;
    logic [SQW-1:0]        r_p;
    logic [MW-1:0]         r_dm;
    logic                  r_dneg;
    logic [MW-1:0]         r_pm;
    logic                  r_pneg;
    logic                  r_in_set;
    logic                  r_valid;

    logic [DIM_W-1:0]      w_c;
    logic [DIM_W-1:0]      h_c;
    logic [PIX_W-1:0]      sel_p;
    logic [PIX_W+1:0]      three_p;
    logic [DVD_W-1:0]      dividend;
    logic [DIM_W-1:0]      divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      quot;
    logic signed [SW-1:0]  map_v;

    logic [CW-1:0]         mx;
    logic [CW-1:0]         my;
    logic [CW-1:0]         mul_a;
    logic [CW-1:0]         mul_b;
    logic                  mul_done;
    logic [SQW-1:0]        prod;

    logic                  dneg;
    logic [SQW-1:0]        dfull;
    logic [DSH_W-1:0]      dsh;
    logic [MW-1:0]         dm;
    logic [DSH_W-1:0]      psh;
    logic [MW-1:0]         pm1;
    logic [MW:0]           pm2;
    logic [MW-1:0]         pm;
    logic signed [SW-1:0]  xs;
    logic signed [SW-1:0]  ys;

    // dimension clamp to [1, MAX_DIM]
    always_comb begin
        if (i_image_width == '0) begin
            w_c = DIM_W'(1);
        end else if (32'(i_image_width) > 32'(MAX_DIM)) begin
            w_c = DIM_W'(MAX_DIM);
        end else begin
            w_c = DIM_W'(i_image_width);
        end
        if (i_image_height == '0) begin
            h_c = DIM_W'(1);
        end else if (32'(i_image_height) > 32'(MAX_DIM)) begin
            h_c = DIM_W'(MAX_DIM);
        end else begin
            h_c = DIM_W'(i_image_height);
        end
    end

    assign sel_p    = i_cmd.load ? i_pixel_x : r_py;
    assign three_p  = {2'b00, sel_p} + {1'b0, sel_p, 1'b0};
    assign dividend = {three_p, {FRAC_BITS{1'b0}}};
    assign divisor  = i_cmd.load ? w_c : h_c;

    mbm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign map_v = $signed({1'b0, quot}) - $signed(i_cmd.set_cx ? OFF_X : OFF_Y);

    // magnitudes for the shared multiplier
    assign mx    = r_x[CW-1] ? CW'(-r_x) : r_x;
    assign my    = r_y[CW-1] ? CW'(-r_y) : r_y;
    assign mul_a = (i_cmd.mul_sel == MSEL_YY) ? my : mx;
    assign mul_b = (i_cmd.mul_sel == MSEL_XX) ? mx : my;

    mbm_mul #(
        .OP_W (CW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // step terms, truncated toward zero and capped
    assign dneg  = (r_sy > r_sx);
    assign dfull = dneg ? (r_sy - r_sx) : (r_sx - r_sy);
    assign dsh   = dfull[SQW-1:FRAC_BITS];
    assign dm    = (dsh > DSH_W'(CAP)) ? CAP : MW'(dsh);
    assign psh   = r_p[SQW-1:FRAC_BITS];
    assign pm1   = (psh > DSH_W'(CAP)) ? CAP : MW'(psh);
    assign pm2   = {pm1, 1'b0};
    assign pm    = (pm2 > {1'b0, CAP}) ? CAP : MW'(pm2);

    assign xs = (r_dneg ? -$signed({2'b00, r_dm}) : $signed({2'b00, r_dm}))
              + $signed({{3{r_cx[CW-1]}}, r_cx});
    assign ys = (r_pneg ? -$signed({2'b00, r_pm}) : $signed({2'b00, r_pm}))
              + $signed({{3{r_cy[CW-1]}}, r_cy});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_py  <= i_pixel_y;
            r_idx <= IDX_W'(i_pixel_y) * IDX_W'(w_c) + IDX_W'(i_pixel_x);
        end
        if (i_cmd.set_cx) begin
            r_cx <= sat_c(map_v);
        end
        if (i_cmd.set_cy) begin
            r_cy <= sat_c(map_v);
            r_x  <= '0;
            r_y  <= '0;
        end else if (i_cmd.update) begin
            r_x <= sat_c(xs);
            r_y <= sat_c(ys);
        end
        if (i_cmd.store) begin
            case (i_cmd.store_sel)
                MSEL_XX: r_sx <= prod;
                MSEL_YY: r_sy <= prod;
                default: r_p  <= prod;
            endcase
        end
        if (i_cmd.prep) begin
            r_dm   <= dm;
            r_dneg <= dneg;
            r_pm   <= pm;
            r_pneg <= r_x[CW-1] ^ r_y[CW-1];
        end
        if (i_cmd.finish) begin
            r_in_set <= i_cmd.in_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.mul_done = mul_done;
    assign o_status.escape   = ({1'b0, r_sx} + {1'b0, r_sy}) > {1'b0, THR};

    assign o_valid       = r_valid;
    assign o_pixel_index = r_idx;
    assign o_in_set      = r_in_set;

endmodule

@@ rtl/mbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbm_ctrl
// sequencer: mapping divisions, orbit products, escape test and step count
// ----------------------------------------------------------------------------
module mbm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [mbm_pkg::ITER_W-1:0]  i_max_iterations,
    output mbm_pkg::t_cmd               o_cmd,
    input  mbm_pkg::t_status            i_status
);
    import mbm_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ITER_W-1:0]   r_iter;
    logic [ITER_W-1:0]   n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_iter          = ITER_W'(1);
                    n_state         = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (i_status.div_done) begin
                    o_cmd.set_cx    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (i_status.div_done) begin
                    o_cmd.set_cy = 1'b1;
                    n_state      = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_XX;
                n_state         = ST_MUL_XX;
            end
            ST_MUL_XX: begin
                if (i_status.mul_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_sel = MSEL_XX;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_YY;
                    n_state         = ST_MUL_YY;
                end
            end
            ST_MUL_YY: begin
                if (i_status.mul_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_sel = MSEL_YY;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_XY;
                    n_state         = ST_MUL_XY;
                end
            end
            ST_MUL_XY: begin
                if (i_status.mul_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_sel = MSEL_XY;
                    n_state         = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.prep = 1'b1;
                if ((r_iter != ITER_W'(1)) && i_status.escape) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.in_set = 1'b0;
                    n_state      = ST_IDLE;
                end else if (r_iter >= i_max_iterations) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.in_set = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_iter       = r_iter + ITER_W'(1);
                n_state      = ST_MUL_GO;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
